// File: hdl/fhd_pkg.sv
// Package for the frame header deframer.
// Holds status codes, header byte positions, register indexes and the result word type.
// No dependencies.
`default_nettype none

package fhd_pkg;

	localparam int unsigned STATUS_W = 3;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LEN_W    = 64;
	localparam int unsigned MAGIC_W  = 32;
	localparam int unsigned IDX_W    = 4;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned TDATA_W  = 2 * BYTE_W + LEN_W;

	localparam logic [STATUS_W-1:0] ST_HEADER_BYTE = 3'd0;
	localparam logic [STATUS_W-1:0] ST_HEADER_DONE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_PAYLOAD     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_MAGIC   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_VERSION = 3'd4;
	localparam logic [STATUS_W-1:0] ST_OVERSIZED   = 3'd5;

	localparam logic [IDX_W-1:0] IDX_VERSION = 4'd4;
	localparam logic [IDX_W-1:0] IDX_TYPE    = 4'd5;
	localparam logic [IDX_W-1:0] IDX_LAST    = 4'd13;

	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CAP     = 2'd2;

	localparam logic [MAGIC_W-1:0] MAGIC_RESET   = 32'd0;
	localparam logic [BYTE_W-1:0]  VERSION_RESET = 8'd3;
	localparam logic [LEN_W-1:0]   CAP_RESET     = 64'd16777216;

	typedef struct packed {
		logic [BYTE_W-1:0]   payload_byte;
		logic [LEN_W-1:0]    payload_length;
		logic [BYTE_W-1:0]   frame_type;
		logic [STATUS_W-1:0] status;
		logic                last;
	} result_t;

endpackage

`default_nettype wire

// File: hdl/frame_header_deframer.sv
// Frame header deframer: checks a 14-byte header, then passes the payload through.
// Depends on fhd_pkg.
//
// channel  dir  handshake                   payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tdata = rx_byte
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata, tuser = status, tlast = last
// cfg      in   cfg_we                       cfg_index, cfg_data
//
// One word per cycle sustained while the output is not stalled; each word passes through the input register
// and then sits in the output register until taken.
// The throughput is set by the single decode step between the two registers.
// Reset clears all control state and loads the register defaults.
// A stalled output holds its word; input is still taken while the input stage is free.
`default_nettype none

module frame_header_deframer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output      logic                          s_axis_tready,
	input  wire logic [7:0]                    s_axis_tdata,   // [7:0] rx_byte
	output      logic                          m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output      logic [fhd_pkg::TDATA_W-1:0]   m_axis_tdata,   // [7:0] frame_type, [71:8] payload_length, [79:72] payload_byte
	output      logic [fhd_pkg::STATUS_W-1:0]  m_axis_tuser,   // [2:0] status
	output      logic                          m_axis_tlast,
	input  wire logic                          cfg_we,
	input  wire logic [fhd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [fhd_pkg::LEN_W-1:0]     cfg_data
);

	logic [fhd_pkg::MAGIC_W-1:0] magic_q;
	logic [fhd_pkg::BYTE_W-1:0]  version_q;
	logic [fhd_pkg::LEN_W-1:0]   cap_q;

	logic                        valid_s1;
	logic [fhd_pkg::BYTE_W-1:0]  byte_s1;

	logic                        in_payload_q, in_payload_n;
	logic [fhd_pkg::IDX_W-1:0]   hdr_idx_q, hdr_idx_n;
	logic                        magic_bad_q, magic_bad_n;
	logic                        version_bad_q, version_bad_n;
	logic [fhd_pkg::BYTE_W-1:0]  type_q, type_n;
	logic [fhd_pkg::LEN_W-1:0]   len_q, len_n;
	logic [fhd_pkg::LEN_W-1:0]   left_q, left_n;

	logic                        out_valid_q;
	fhd_pkg::result_t            res_q, res_n;

	logic                        adv_out;
	logic                        fire;
	logic [fhd_pkg::BYTE_W-1:0]  magic_want;

	assign adv_out       = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && adv_out;
	assign s_axis_tready = !valid_s1 || adv_out;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {res_q.payload_byte, res_q.payload_length, res_q.frame_type};
	assign m_axis_tuser  = res_q.status;
	assign m_axis_tlast  = res_q.last;

	always_comb begin
		case (hdr_idx_q[1:0])
			2'd0:    magic_want = magic_q[31:24];
			2'd1:    magic_want = magic_q[23:16];
			2'd2:    magic_want = magic_q[15:8];
			default: magic_want = magic_q[7:0];
		endcase
	end

	always_comb begin
		in_payload_n  = in_payload_q;
		hdr_idx_n     = hdr_idx_q;
		magic_bad_n   = magic_bad_q;
		version_bad_n = version_bad_q;
		type_n        = type_q;
		len_n         = len_q;
		left_n        = left_q;
		res_n         = '0;
		res_n.status  = fhd_pkg::ST_HEADER_BYTE;

		if (in_payload_q) begin
			res_n.status         = fhd_pkg::ST_PAYLOAD;
			res_n.frame_type     = type_q;
			res_n.payload_length = len_q;
			res_n.payload_byte   = byte_s1;
			left_n               = left_q - 64'd1;
			if (left_q == 64'd1) begin
				res_n.last    = 1'b1;
				in_payload_n  = 1'b0;
				hdr_idx_n     = '0;
				magic_bad_n   = 1'b0;
				version_bad_n = 1'b0;
			end
		end else begin
			if (hdr_idx_q < fhd_pkg::IDX_VERSION) begin
				if (byte_s1 != magic_want) begin
					magic_bad_n = 1'b1;
				end
			end else if (hdr_idx_q == fhd_pkg::IDX_VERSION) begin
				if (byte_s1 != version_q) begin
					version_bad_n = 1'b1;
				end
			end else if (hdr_idx_q == fhd_pkg::IDX_TYPE) begin
				type_n = byte_s1;
			end else begin
				len_n = {len_q[fhd_pkg::LEN_W-fhd_pkg::BYTE_W-1:0], byte_s1};
			end

			if (hdr_idx_q >= fhd_pkg::IDX_LAST) begin
				in_payload_n  = 1'b0;
				hdr_idx_n     = '0;
				magic_bad_n   = 1'b0;
				version_bad_n = 1'b0;
				if (magic_bad_q) begin
					res_n.status = fhd_pkg::ST_BAD_MAGIC;
				end else if (version_bad_q) begin
					res_n.status = fhd_pkg::ST_BAD_VERSION;
				end else if (len_n > cap_q) begin
					res_n.status = fhd_pkg::ST_OVERSIZED;
				end else begin
					res_n.status         = fhd_pkg::ST_HEADER_DONE;
					res_n.frame_type     = type_n;
					res_n.payload_length = len_n;
					if (len_n == '0) begin
						res_n.last = 1'b1;
					end else begin
						in_payload_n = 1'b1;
						left_n       = len_n;
					end
				end
			end else begin
				hdr_idx_n = hdr_idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= fhd_pkg::MAGIC_RESET;
			version_q <= fhd_pkg::VERSION_RESET;
			cap_q     <= fhd_pkg::CAP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				fhd_pkg::CFG_MAGIC:   magic_q   <= cfg_data[fhd_pkg::MAGIC_W-1:0];
				fhd_pkg::CFG_VERSION: version_q <= cfg_data[fhd_pkg::BYTE_W-1:0];
				fhd_pkg::CFG_CAP:     cap_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q  <= 1'b0;
			hdr_idx_q     <= '0;
			magic_bad_q   <= 1'b0;
			version_bad_q <= 1'b0;
			type_q        <= '0;
			len_q         <= '0;
			left_q        <= '0;
		end else if (fire) begin
			in_payload_q  <= in_payload_n;
			hdr_idx_q     <= hdr_idx_n;
			magic_bad_q   <= magic_bad_n;
			version_bad_q <= version_bad_n;
			type_q        <= type_n;
			len_q         <= len_n;
			left_q        <= left_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_n;
		end
	end

endmodule

`default_nettype wire

// File: hdl/fhd_checks.sv
// Port-level checks for the frame header deframer, bound to the top level.
// Depends on fhd_pkg and frame_header_deframer.
`default_nettype none

module fhd_checks (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          m_axis_tvalid,
	input wire logic                          m_axis_tready,
	input wire logic [fhd_pkg::TDATA_W-1:0]   m_axis_tdata,
	input wire logic [fhd_pkg::STATUS_W-1:0]  m_axis_tuser,
	input wire logic                          m_axis_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser <= fhd_pkg::ST_OVERSIZED)
		else $error("status code out of range");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |->
			m_axis_tuser == fhd_pkg::ST_HEADER_DONE || m_axis_tuser == fhd_pkg::ST_PAYLOAD)
		else $error("last on a word that is not header done or payload");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != fhd_pkg::ST_HEADER_DONE
			&& m_axis_tuser != fhd_pkg::ST_PAYLOAD |-> m_axis_tdata == '0)
		else $error("header byte or error word carries data");

	a_done_nobyte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == fhd_pkg::ST_HEADER_DONE |->
			m_axis_tdata[fhd_pkg::TDATA_W-1 -: fhd_pkg::BYTE_W] == '0
			&& (m_axis_tlast == (m_axis_tdata[fhd_pkg::TDATA_W-fhd_pkg::BYTE_W-1:
				fhd_pkg::BYTE_W] == '0)))
		else $error("header done word inconsistent with its length");

endmodule

bind frame_header_deframer fhd_checks u_fhd_checks (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: tb/sv/frame_header_deframer_tb.sv
// Testbench for the frame header deframer: directed and random byte streams with
// bursty input, stalling output and register changes; every output word is predicted and checked.
// Depends on fhd_pkg and frame_header_deframer.

module frame_header_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned SWEEP_BYTES  = 150;

	localparam logic [fhd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	localparam logic [fhd_pkg::MAGIC_W-1:0] RESET_MAGIC   = 32'd0;
	localparam logic [fhd_pkg::BYTE_W-1:0]  RESET_VERSION = 8'd3;
	localparam logic [fhd_pkg::LEN_W-1:0]   RESET_CAP     = 64'd16777216;

	typedef enum {FK_GOOD, FK_BAD_MAGIC, FK_BAD_VERSION, FK_OVERSIZED, FK_MULTI_FAULT,
		FK_NOISE} frame_kind_t;
	typedef enum {PACE_FULL, PACE_LIGHT, PACE_PERIODIC, PACE_HEAVY} rx_pace_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              s_axis_tvalid = 1'b0;
	logic                              s_axis_tready;
	logic [7:0]                        s_axis_tdata = '0;   // [7:0] rx_byte
	logic                              m_axis_tvalid;
	logic                              m_axis_tready = 1'b0;
	logic [fhd_pkg::TDATA_W-1:0]       m_axis_tdata;        // [7:0] frame_type,
	                                                        // [71:8] payload_length,
	                                                        // [79:72] payload_byte
	logic [fhd_pkg::STATUS_W-1:0]      m_axis_tuser;        // [2:0] status
	logic                              m_axis_tlast;
	logic                              cfg_we = 1'b0;
	logic [fhd_pkg::CFG_IDX_W-1:0]     cfg_index = fhd_pkg::CFG_MAGIC;
	logic [fhd_pkg::LEN_W-1:0]         cfg_data = '0;

	// register copies
	logic [fhd_pkg::MAGIC_W-1:0]       want_magic = RESET_MAGIC;
	logic [fhd_pkg::BYTE_W-1:0]        want_version = RESET_VERSION;
	logic [fhd_pkg::LEN_W-1:0]         length_cap = RESET_CAP;

	// header tracking state
	logic                              hdr_in_payload = 1'b0;
	logic [fhd_pkg::IDX_W-1:0]         hdr_pos = '0;
	logic                              hdr_magic_bad = 1'b0;
	logic                              hdr_version_bad = 1'b0;
	logic [fhd_pkg::BYTE_W-1:0]        hdr_type = '0;
	logic [fhd_pkg::LEN_W-1:0]         hdr_length = '0;
	logic [fhd_pkg::LEN_W-1:0]         payload_left = '0;

	fhd_pkg::result_t                  words_due[$];
	int unsigned                       mismatches = 0;
	int unsigned                       words_seen = 0;
	int unsigned                       bytes_sent = 0;
	int unsigned                       cycle_count = 0;
	int unsigned                       tx_burst_left = 0;
	int unsigned                       rx_hold_left = 0;
	int unsigned                       rx_pace_left = 0;
	int unsigned                       rx_tick = 0;
	rx_pace_t                          rx_pace = PACE_FULL;

	frame_header_deframer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic void restart_header();
		hdr_in_payload = 1'b0;
		hdr_pos = '0;
		hdr_magic_bad = 1'b0;
		hdr_version_bad = 1'b0;
	endfunction

	function automatic fhd_pkg::result_t deframe_byte(input logic [7:0] b);
		fhd_pkg::result_t r;
		logic [fhd_pkg::IDX_W-1:0] pos;
		r = '0;
		r.status = fhd_pkg::ST_HEADER_BYTE;
		if (hdr_in_payload) begin
			r.status = fhd_pkg::ST_PAYLOAD;
			r.frame_type = hdr_type;
			r.payload_length = hdr_length;
			r.payload_byte = b;
			payload_left = payload_left - 64'd1;
			if (payload_left == 0) begin
				r.last = 1'b1;
				restart_header();
			end
		end else begin
			pos = hdr_pos;
			if (pos < fhd_pkg::IDX_VERSION) begin
				if (b != want_magic[31 - 8 * pos -: 8])
					hdr_magic_bad = 1'b1;
			end else if (pos == fhd_pkg::IDX_VERSION) begin
				if (b != want_version)
					hdr_version_bad = 1'b1;
			end else if (pos == fhd_pkg::IDX_TYPE) begin
				hdr_type = b;
			end else begin
				hdr_length = {hdr_length[fhd_pkg::LEN_W-9:0], b};
			end
			if (pos >= fhd_pkg::IDX_LAST) begin
				if (hdr_magic_bad)
					r.status = fhd_pkg::ST_BAD_MAGIC;
				else if (hdr_version_bad)
					r.status = fhd_pkg::ST_BAD_VERSION;
				else if (hdr_length > length_cap)
					r.status = fhd_pkg::ST_OVERSIZED;
				else begin
					r.status = fhd_pkg::ST_HEADER_DONE;
					r.frame_type = hdr_type;
					r.payload_length = hdr_length;
				end
				restart_header();
				if (r.status == fhd_pkg::ST_HEADER_DONE) begin
					if (hdr_length == 0)
						r.last = 1'b1;
					else begin
						hdr_in_payload = 1'b1;
						payload_left = hdr_length;
					end
				end
			end else begin
				hdr_pos = pos + 4'd1;
			end
		end
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [fhd_pkg::LEN_W-1:0] got,
		input logic [fhd_pkg::LEN_W-1:0] want);
		$display("mismatch in %s at word %0d: got 0x%0h, want 0x%0h",
			what, words_seen, got, want);
		mismatches++;
	endtask

	task automatic take_result();
		fhd_pkg::result_t want;
		if (words_due.size() == 0) begin
			flag_mismatch("unexpected word status", 64'(m_axis_tuser), '0);
			return;
		end
		want = words_due.pop_front();
		if (m_axis_tuser !== want.status)
			flag_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
		if (m_axis_tdata[7:0] !== want.frame_type)
			flag_mismatch("frame_type", 64'(m_axis_tdata[7:0]), 64'(want.frame_type));
		if (m_axis_tdata[71:8] !== want.payload_length)
			flag_mismatch("payload_length", m_axis_tdata[71:8], want.payload_length);
		if (m_axis_tdata[79:72] !== want.payload_byte)
			flag_mismatch("payload_byte", 64'(m_axis_tdata[79:72]),
				64'(want.payload_byte));
		if (m_axis_tlast !== want.last)
			flag_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
		words_seen++;
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
			take_result();
		rx_tick++;
		if (rx_pace_left == 0) begin
			rx_pace = rx_pace_t'($urandom_range(0, 3));
			rx_pace_left = $urandom_range(16, 300);
		end else begin
			rx_pace_left--;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_pace)
			PACE_FULL:     m_axis_tready <= 1'b1;
			PACE_LIGHT:    m_axis_tready <= ($urandom_range(0, 3) != 0);
			PACE_PERIODIC: m_axis_tready <= ((rx_tick % 5) >= 2);
			default:       m_axis_tready <= ($urandom_range(0, 9) < 3);
			endcase
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		if (tx_burst_left == 0) begin
			tx_burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				s_axis_tdata <= 8'($urandom);
				repeat (gap) @(posedge clk);
			end
		end
		tx_burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		words_due.push_back(deframe_byte(b));
		bytes_sent++;
	endtask

	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		tx_burst_left = 0;
		while (words_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [fhd_pkg::CFG_IDX_W-1:0] idx,
		input logic [fhd_pkg::LEN_W-1:0] data);
		wait_for_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
		fhd_pkg::CFG_MAGIC:   want_magic = data[fhd_pkg::MAGIC_W-1:0];
		fhd_pkg::CFG_VERSION: want_version = data[fhd_pkg::BYTE_W-1:0];
		fhd_pkg::CFG_CAP:     length_cap = data;
		default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [fhd_pkg::MAGIC_W-1:0] magic,
		input logic [fhd_pkg::BYTE_W-1:0] version, input logic [fhd_pkg::LEN_W-1:0] cap);
		write_reg(fhd_pkg::CFG_MAGIC, {32'($urandom), magic});
		write_reg(fhd_pkg::CFG_VERSION, {32'($urandom), 24'($urandom), version});
		write_reg(fhd_pkg::CFG_CAP, cap);
	endtask

	task automatic send_header(input logic [fhd_pkg::MAGIC_W-1:0] magic,
		input logic [7:0] version, input logic [7:0] ftype,
		input logic [fhd_pkg::LEN_W-1:0] len);
		for (int i = 0; i < 4; i++)
			send_byte(magic[31 - 8 * i -: 8]);
		send_byte(version);
		send_byte(ftype);
		for (int i = 0; i < 8; i++)
			send_byte(len[63 - 8 * i -: 8]);
	endtask

	// every noise header starts with a wrong magic byte, so none can open a payload
	task automatic send_noise();
		int unsigned count;
		logic [7:0] b;
		count = $urandom_range(1, 30);
		while (count > 0 || hdr_pos != 0) begin
			b = 8'($urandom);
			if (hdr_pos == 0 && b == want_magic[31:24])
				b = ~b;
			send_byte(b);
			if (count > 0)
				count--;
		end
	endtask

	task automatic send_frame(input frame_kind_t kind);
		logic [fhd_pkg::MAGIC_W-1:0] magic;
		logic [7:0] version;
		logic [fhd_pkg::LEN_W-1:0] len;
		bit bad_magic, bad_version, oversize;
		int unsigned pick, top;
		if (kind == FK_NOISE) begin
			send_noise();
			return;
		end
		magic = want_magic;
		version = want_version;
		bad_magic = (kind == FK_BAD_MAGIC);
		bad_version = (kind == FK_BAD_VERSION);
		oversize = (kind == FK_OVERSIZED);
		if (kind == FK_MULTI_FAULT) begin
			pick = $urandom_range(0, 3);
			bad_magic = (pick != 2);
			bad_version = (pick != 1);
			oversize = (pick != 0);
		end
		if (length_cap == '1)
			oversize = 1'b0;
		if (bad_magic) begin
			pick = $urandom_range(0, 3);
			magic[8 * pick +: 8] = magic[8 * pick +: 8] ^ 8'($urandom_range(1, 255));
		end
		if (bad_version)
			version = version ^ 8'($urandom_range(1, 255));
		top = (length_cap < 64'd64) ? int'(length_cap) : 64;
		if (oversize) begin
			case ($urandom_range(0, 2))
			0: len = length_cap + 64'd1;
			1: len = '1;
			default: begin
				len = length_cap + 64'd1 + 64'($urandom);
				if (len <= length_cap)
					len = '1;
			end
			endcase
		end else if (bad_magic || bad_version) begin
			len = $urandom_range(0, 1) ? {32'($urandom), 32'($urandom)}
				: 64'($urandom_range(0, 12));
		end else begin
			case ($urandom_range(0, 9))
			0:       len = 64'(top);
			1, 2:    len = 64'($urandom_range(0, top));
			default: len = 64'($urandom_range(0, (top < 12) ? top : 12));
			endcase
		end
		send_header(magic, version, 8'($urandom), len);
		if (!bad_magic && !bad_version && !oversize)
			for (int i = 0; i < int'(len); i++)
				send_byte(8'($urandom));
	endtask

	task automatic send_random_frames(input int unsigned n_bytes);
		int unsigned start, r;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				send_frame(FK_GOOD);
			else if (r < 67)
				send_frame(FK_BAD_MAGIC);
			else if (r < 77)
				send_frame(FK_BAD_VERSION);
			else if (r < 87)
				send_frame(FK_OVERSIZED);
			else if (r < 93)
				send_frame(FK_MULTI_FAULT);
			else
				send_frame(FK_NOISE);
		end
	endtask

	task automatic test_directed_frames();
		send_header(RESET_MAGIC, RESET_VERSION, 8'hFF, 64'd0);
		send_header(RESET_MAGIC, RESET_VERSION, 8'h00, 64'd1);
		send_byte(8'hFF);
		wait_for_results();
	endtask

	task automatic test_bad_magic();
		repeat (8) send_frame(FK_BAD_MAGIC);
		wait_for_results();
	endtask

	task automatic test_bad_version();
		repeat (6) send_frame(FK_BAD_VERSION);
		wait_for_results();
	endtask

	task automatic test_oversized();
		repeat (6) send_frame(FK_OVERSIZED);
		wait_for_results();
	endtask

	task automatic test_fault_priority();
		repeat (6) send_frame(FK_MULTI_FAULT);
		wait_for_results();
	endtask

	// hold the output while the input keeps offering words
	task automatic test_output_holdoff();
		rx_hold_left = HOLD_CYCLES;
		repeat (3) send_frame(FK_GOOD);
		wait_for_results();
	endtask

	task automatic test_sender_pause();
		repeat (4) begin
			send_random_frames(40);
			wait_for_results();
		end
	endtask

	task automatic test_config_sweep();
		apply_settings('1, 8'hFF, '1);
		send_random_frames(SWEEP_BYTES);
		apply_settings('0, 8'h00, '0);
		write_reg(CFG_UNUSED, {32'($urandom), 32'($urandom)});
		send_random_frames(SWEEP_BYTES);
		apply_settings(32'($urandom), 8'($urandom), 64'd1);
		send_random_frames(SWEEP_BYTES);
		apply_settings(32'($urandom), 8'($urandom), 64'($urandom_range(2, 63)));
		send_random_frames(SWEEP_BYTES);
		apply_settings(32'h8000_0001, 8'h80, 64'h8000_0000_0000_0000);
		send_random_frames(SWEEP_BYTES);
		apply_settings(32'($urandom), 8'($urandom), {32'($urandom), 32'($urandom)});
		send_random_frames(SWEEP_BYTES);
		apply_settings(32'($urandom), 8'($urandom), 64'd40);
		send_random_frames(SWEEP_BYTES);
		wait_for_results();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_frames();
		test_bad_magic();
		test_bad_version();
		test_oversized();
		test_fault_priority();
		test_output_holdoff();
		test_sender_pause();
		test_config_sweep();
		wait_for_results();
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
